// ----- rtl/core/svle_pkg.sv -----
// ----------------------------------------------------------------------------
// svle_pkg
// Types and codes shared by the sorted value list engine: operation and
// status codes, controller states, and the command and status bundles.
// ----------------------------------------------------------------------------
package svle_pkg;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_SORT   = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_DUMP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT_LD,
        S_SORT_CMP,
        S_SORT_WB,
        S_REM_SCAN,
        S_REM_SHIFT,
        S_DUMP,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        RA_ZERO,
        RA_I1,
        RA_J1
    } ra_sel_t;

    typedef enum logic [1:0] {
        WA_COUNT,
        WA_I,
        WA_J,
        WA_JM1
    } wa_sel_t;

    typedef enum logic [1:0] {
        WD_INPUT,
        WD_CUR,
        WD_RDATA
    } wd_sel_t;

    typedef struct packed {
        logic    rd_en;
        ra_sel_t ra_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        logic    cur_load;
        logic    i_clr;
        logic    i_inc;
        logic    j_clr;
        logic    j_set;
        logic    j_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    val_load;
        logic    emit;
        status_t emit_status;
        logic    emit_item;
        logic    emit_last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic small_list;
        logic i_last;
        logic j_last;
        logic greater;
        logic match;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/core/svle_dp.sv -----
// ----------------------------------------------------------------------------
// svle_dp
// Datapath: single-port-write entry store with registered read, scan
// counters, fill count, held candidate and the result word register.
// ----------------------------------------------------------------------------
module svle_dp #(
    parameter int CAPACITY = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  svle_pkg::cmd_t   cmd,
    input  logic [31:0]      in_value,
    input  logic             m_tready,
    output svle_pkg::stat_t  stat,
    output logic             m_tvalid,
    output logic [31:0]      m_tdata,   // item
    output logic [1:0]       m_tuser,   // status
    output logic             m_tlast
);
    import svle_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_reg;
    logic signed [31:0] cur_reg;
    logic signed [31:0] val_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      count_reg;
    logic               out_valid_reg;
    logic [31:0]        out_item_reg;
    status_t            out_status_reg;
    logic               out_last_reg;

    logic [CW-1:0]      i_inc1;
    logic [CW-1:0]      j_inc1;
    logic [CW-1:0]      j_dec1;
    logic [CW-1:0]      cnt_m1;
    logic [CW-1:0]      cnt_m2;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;

    assign i_inc1 = i_reg + CW'(1);
    assign j_inc1 = j_reg + CW'(1);
    assign j_dec1 = j_reg - CW'(1);
    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);

    always_comb begin
        unique case (cmd.ra_sel)
            RA_ZERO: raddr = '0;
            RA_I1:   raddr = i_inc1[AW-1:0];
            RA_J1:   raddr = j_inc1[AW-1:0];
            default: raddr = '0;
        endcase
    end

    always_comb begin
        unique case (cmd.wa_sel)
            WA_COUNT: waddr = count_reg[AW-1:0];
            WA_I:     waddr = i_reg[AW-1:0];
            WA_J:     waddr = j_reg[AW-1:0];
            WA_JM1:   waddr = j_dec1[AW-1:0];
            default:  waddr = '0;
        endcase
    end

    always_comb begin
        unique case (cmd.wd_sel)
            WD_INPUT: wdata = in_value;
            WD_CUR:   wdata = cur_reg;
            WD_RDATA: wdata = rdata_reg;
            default:  wdata = in_value;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cur_load) begin
            cur_reg <= rdata_reg;
        end
        if (cmd.val_load) begin
            val_reg <= in_value;
        end
        if (cmd.i_clr) begin
            i_reg <= '0;
        end else if (cmd.i_inc) begin
            i_reg <= i_inc1;
        end
        if (cmd.j_clr) begin
            j_reg <= '0;
        end else if (cmd.j_set) begin
            j_reg <= i_inc1;
        end else if (cmd.j_inc) begin
            j_reg <= j_inc1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.cnt_inc) begin
            count_reg <= count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_reg <= cnt_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_item_reg   <= cmd.emit_item ? rdata_reg : '0;
            out_status_reg <= cmd.emit_status;
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign stat.full       = (count_reg == CW'(CAPACITY));
    assign stat.empty      = (count_reg == '0);
    assign stat.small_list = (count_reg <= CW'(1));
    assign stat.i_last     = (i_reg == cnt_m2);
    assign stat.j_last     = (j_reg == cnt_m1);
    assign stat.greater    = (cur_reg > rdata_reg);
    assign stat.match      = (rdata_reg == val_reg);
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_inc |-> !stat.full && cmd.wr_en)
        else $error("append into full store");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result word overwritten before taken");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> out_valid_reg)
        else $error("emitted word not presented");

endmodule

// ----- rtl/core/svle_ctrl.sv -----
// ----------------------------------------------------------------------------
// svle_ctrl
// Controller: decodes each operation and sequences the append, exchange
// sort, remove-and-close-gap and dump walks over the datapath.
// ----------------------------------------------------------------------------
module svle_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  svle_pkg::func_t  in_func,
    input  svle_pkg::stat_t  stat,
    output svle_pkg::cmd_t   cmd
);
    import svle_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    status_t resp_reg;
    status_t resp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            resp_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        resp_next  = resp_reg;
        s_tready   = (state_reg == S_IDLE) && stat.out_free;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.val_load = 1'b1;
                    unique case (in_func)
                        FUNC_APPEND: begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            if (stat.full) begin
                                cmd.emit_status = ST_FULL;
                            end else begin
                                cmd.wr_en   = 1'b1;
                                cmd.wa_sel  = WA_COUNT;
                                cmd.wd_sel  = WD_INPUT;
                                cmd.cnt_inc = 1'b1;
                            end
                        end
                        FUNC_SORT: begin
                            if (stat.small_list) begin
                                cmd.emit      = 1'b1;
                                cmd.emit_last = 1'b1;
                            end else begin
                                cmd.i_clr  = 1'b1;
                                cmd.rd_en  = 1'b1;
                                cmd.ra_sel = RA_ZERO;
                                state_next = S_SORT_LD;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (stat.empty) begin
                                cmd.emit        = 1'b1;
                                cmd.emit_last   = 1'b1;
                                cmd.emit_status = ST_EMPTY;
                            end else begin
                                cmd.j_clr  = 1'b1;
                                cmd.rd_en  = 1'b1;
                                cmd.ra_sel = RA_ZERO;
                                state_next = S_REM_SCAN;
                            end
                        end
                        FUNC_DUMP: begin
                            if (stat.empty) begin
                                cmd.emit        = 1'b1;
                                cmd.emit_last   = 1'b1;
                                cmd.emit_status = ST_EMPTY;
                            end else begin
                                cmd.j_clr  = 1'b1;
                                cmd.rd_en  = 1'b1;
                                cmd.ra_sel = RA_ZERO;
                                state_next = S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SORT_LD: begin
                cmd.cur_load = 1'b1;
                cmd.j_set    = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.ra_sel   = RA_I1;
                state_next   = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if (stat.greater) begin
                    cmd.wr_en    = 1'b1;
                    cmd.wa_sel   = WA_J;
                    cmd.wd_sel   = WD_CUR;
                    cmd.cur_load = 1'b1;
                end
                if (stat.j_last) begin
                    state_next = S_SORT_WB;
                end else begin
                    cmd.j_inc  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = RA_J1;
                end
            end
            S_SORT_WB: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_I;
                cmd.wd_sel = WD_CUR;
                if (stat.i_last) begin
                    resp_next  = ST_OK;
                    state_next = S_RESP;
                end else begin
                    cmd.i_inc  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = RA_I1;
                    state_next = S_SORT_LD;
                end
            end
            S_REM_SCAN: begin
                priority if (stat.match && stat.j_last) begin
                    cmd.cnt_dec = 1'b1;
                    resp_next   = ST_OK;
                    state_next  = S_RESP;
                end else if (stat.match) begin
                    cmd.j_inc  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = RA_J1;
                    state_next = S_REM_SHIFT;
                end else if (stat.j_last) begin
                    resp_next  = ST_NOT_FOUND;
                    state_next = S_RESP;
                end else begin
                    cmd.j_inc  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = RA_J1;
                end
            end
            S_REM_SHIFT: begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_JM1;
                cmd.wd_sel = WD_RDATA;
                if (stat.j_last) begin
                    cmd.cnt_dec = 1'b1;
                    resp_next   = ST_OK;
                    state_next  = S_RESP;
                end else begin
                    cmd.j_inc  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.ra_sel = RA_J1;
                end
            end
            S_DUMP: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_item = 1'b1;
                    cmd.emit_last = stat.j_last;
                    if (stat.j_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.j_inc  = 1'b1;
                        cmd.rd_en  = 1'b1;
                        cmd.ra_sel = RA_J1;
                    end
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = resp_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/sorted_value_list_engine.sv -----
// ----------------------------------------------------------------------------
// sorted_value_list_engine
// Bounded list of signed 32-bit values: append, exchange sort ascending,
// remove first match, and dump of all entries in order.
// A dump sends one word a cycle while the result register is free, and
// output back-pressure stalls every result word.
// Throughput: one operation at a time; the next word is taken once the
// final result word is loaded and the result register is free, so
// appends run one a cycle while the receiver keeps up.
// Reset clears the fill count and the output valid flag; entries stay undefined.
// ----------------------------------------------------------------------------
module sorted_value_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // item
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast
);
    import svle_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    func_t in_func;

    assign in_func = func_t'(s_tuser);

    svle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_func  (in_func),
        .stat     (stat),
        .cmd      (cmd)
    );

    svle_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_value (s_tdata),
        .m_tready (m_tready),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- bench/sorted_value_list_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_value_list_engine_tb
// Drives append, sort, remove and dump commands into the value list engine
// and mirrors the list in a tracker object. The tracker predicts every
// result word (status, item, last) and checks each one as it leaves the
// block. The sender and the receiver both idle at random.
// ----------------------------------------------------------------------------
module sorted_value_list_engine_tb;
    import svle_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_WORDS = 280;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        status_t     status;
        logic [31:0] item;
        logic        last;
    } list_word_t;

    class value_list_tracker #(int CAP = 32);
        logic signed [31:0] values [CAP];
        int                 fill;
        int                 errors;
        list_word_t         pending_words [$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void push_word(status_t st, logic [31:0] item, logic last);
            list_word_t w;
            w.status = st;
            w.item   = item;
            w.last   = last;
            pending_words.push_back(w);
        endfunction

        function void apply_command(func_t op, logic [31:0] value);
            logic signed [31:0] held;
            int                 hit;
            case (op)
                FUNC_APPEND: begin
                    if (fill >= CAP) begin
                        push_word(ST_FULL, '0, 1'b1);
                    end else begin
                        values[fill] = value;
                        fill++;
                        push_word(ST_OK, '0, 1'b1);
                    end
                end
                FUNC_SORT: begin
                    for (int i = 0; i < fill; i++) begin
                        for (int j = i + 1; j < fill; j++) begin
                            if (values[i] > values[j]) begin
                                held      = values[i];
                                values[i] = values[j];
                                values[j] = held;
                            end
                        end
                    end
                    push_word(ST_OK, '0, 1'b1);
                end
                FUNC_REMOVE: begin
                    hit = -1;
                    for (int i = 0; i < fill && hit < 0; i++) begin
                        if (values[i] == value) hit = i;
                    end
                    if (fill == 0) begin
                        push_word(ST_EMPTY, '0, 1'b1);
                    end else if (hit < 0) begin
                        push_word(ST_NOT_FOUND, '0, 1'b1);
                    end else begin
                        for (int j = hit; j + 1 < fill; j++) values[j] = values[j + 1];
                        fill--;
                        push_word(ST_OK, '0, 1'b1);
                    end
                end
                default: begin
                    if (fill == 0) begin
                        push_word(ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            push_word(ST_OK, values[i], i == fill - 1);
                        end
                    end
                end
            endcase
        endfunction

        function void check_word(logic [1:0] st, logic [31:0] item, logic last);
            list_word_t w;
            if (pending_words.size() == 0) begin
                $error("unexpected result word: status %0d item %h last %b", st, item, last);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            if (st !== w.status) begin
                $error("status: expected %0d, got %0d", w.status, st);
                errors++;
            end
            if (item !== w.item) begin
                $error("item: expected %h, got %h", w.item, item);
                errors++;
            end
            if (last !== w.last) begin
                $error("last: expected %b, got %b", w.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    value_list_tracker #(CAPACITY) tracker;

    int       cycles;
    int       words_sent;
    int       burst_left;
    int       ready_hold;
    int       ready_mode;
    bit [1:0] stall_phase;

    sorted_value_list_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        cycles      = 0;
        words_sent  = 0;
        burst_left  = 0;
        ready_hold  = 0;
        ready_mode  = 0;
        stall_phase = '0;
        tracker     = new();
    end

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: ready always, ready at random, or ready when a two-bit phase counter reaches three
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 2'd1;
        if (ready_hold == 0) begin
            ready_mode <= $urandom_range(0, 2);
            ready_hold <= $urandom_range(8, 64);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (stall_phase == 2'd3);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_word(m_tuser, m_tdata, m_tlast);
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return $urandom_range(0, 8) - 4;
            3:       return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] held_value();
        if (tracker.fill == 0 || $urandom_range(0, 4) == 0) return pick_value();
        return tracker.values[$urandom_range(0, tracker.fill - 1)];
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(func_t op, logic [31:0] value);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.apply_command(op, value);
        words_sent++;
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic fill_run();
        int n;
        n = CAPACITY - tracker.fill + $urandom_range(0, 3);
        repeat (n) send_word(FUNC_APPEND, pick_value());
        send_word(FUNC_DUMP, $urandom());
    endtask

    task automatic drain_run();
        int n;
        n = tracker.fill + $urandom_range(0, 2);
        repeat (n) send_word(FUNC_REMOVE, held_value());
        send_word(FUNC_DUMP, $urandom());
    endtask

    task automatic mixed_run();
        int pick;
        repeat (16) begin
            pick = $urandom_range(0, 19);
            if (pick < 8)       send_word(FUNC_APPEND, pick_value());
            else if (pick < 11) send_word(FUNC_SORT, $urandom());
            else if (pick < 16) send_word(FUNC_REMOVE, held_value());
            else                send_word(FUNC_DUMP, $urandom());
        end
    endtask

    task automatic sort_run();
        repeat ($urandom_range(0, 5)) send_word(FUNC_APPEND, pick_value());
        send_word(FUNC_SORT, $urandom());
        send_word(FUNC_DUMP, $urandom());
    endtask

    initial begin
        int target;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_word(FUNC_DUMP, 32'h0000_0000);
        send_word(FUNC_REMOVE, 32'h0000_0005);
        send_word(FUNC_SORT, 32'hffff_ffff);
        send_word(FUNC_APPEND, 32'h8000_0000);
        send_word(FUNC_SORT, 32'h0000_0000);
        send_word(FUNC_DUMP, 32'hffff_ffff);
        send_word(FUNC_APPEND, 32'h7fff_ffff);
        send_word(FUNC_APPEND, 32'hffff_ffff);
        send_word(FUNC_APPEND, 32'h0000_0000);
        send_word(FUNC_APPEND, 32'h0000_0001);
        send_word(FUNC_APPEND, 32'h7fff_ffff);
        send_word(FUNC_DUMP, 32'h0000_0000);
        send_word(FUNC_SORT, 32'h0000_0000);
        send_word(FUNC_DUMP, 32'h0000_0000);
        send_word(FUNC_REMOVE, 32'h0000_04d2);
        send_word(FUNC_REMOVE, 32'h7fff_ffff);
        send_word(FUNC_DUMP, 32'h0000_0000);
        send_word(FUNC_REMOVE, 32'h8000_0000);
        send_word(FUNC_REMOVE, 32'hffff_ffff);
        send_word(FUNC_DUMP, 32'h0000_0000);

        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1:    fill_run();
                2, 3:    drain_run();
                8, 9:    sort_run();
                default: mixed_run();
            endcase
        end
        s_tvalid <= 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
